### src/vertex_diffuse_fresnel_shader_assert.svh
// ----------------------------------------------------------------------------
// Vertex diffuse fresnel shader assertion macros
// Shared property forms for the shader checkers; clk and rst_n come from scope.
// ----------------------------------------------------------------------------
`ifndef VERTEX_DIFFUSE_FRESNEL_SHADER_ASSERT_SVH
`define VERTEX_DIFFUSE_FRESNEL_SHADER_ASSERT_SVH

// same-cycle implication
`define VDFS_ASSERT_SAME(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define VDFS_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

### src/vdfs_pkg.sv
// ----------------------------------------------------------------------------
// Vertex diffuse fresnel shader package
// Request and register codes, vector types and state encodings.
// ----------------------------------------------------------------------------
package vdfs_pkg;

    localparam int DEF_MAX_TEXELS = 65536;
    localparam int DEF_MAX_LIGHTS = 8;

    localparam logic [1:0] REQ_TEXEL = 2'd0;
    localparam logic [1:0] REQ_LIGHT = 2'd1;
    localparam logic [1:0] REQ_SHADE = 2'd2;

    localparam logic [1:0] CFG_TEX_WIDTH    = 2'd0;
    localparam logic [1:0] CFG_TEX_HEIGHT   = 2'd1;
    localparam logic [1:0] CFG_LIGHT_COUNT  = 2'd2;
    localparam logic [1:0] CFG_FRESNEL_GAIN = 2'd3;

    localparam logic [14:0] ONE_Q14 = 15'd16384;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
    } vec34_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } nvec_t;

    typedef enum logic [2:0] {
        U_IDLE,
        U_SHIFT,
        U_SQ,
        U_SQRT,
        U_DIV,
        U_DONE
    } unit_st_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_UMUL,
        S_MODU,
        S_MODV,
        S_ADDR,
        S_RED,
        S_TWR,
        S_TRD,
        S_TLAT,
        S_NSTART,
        S_NWAIT,
        S_VSTART,
        S_VWAIT,
        S_LRD,
        S_LSTART,
        S_LWAIT,
        S_LDOT,
        S_LACC,
        S_VDOT,
        S_RIM1,
        S_RIM2,
        S_CH,
        S_OUT
    } shd_st_t;

endpackage

### src/vertex_diffuse_fresnel_shader.sv
// ----------------------------------------------------------------------------
// Vertex diffuse fresnel shader
// Texel and light stores with a sequenced Lambert plus fresnel rim shader.
// ----------------------------------------------------------------------------
//  channel   signals                                    direction
//  config    cfg_we cfg_index cfg_data                  write only
//  request   in_valid in_ready req_type..value          in
//  result    out_valid out_ready red green blue         out
//
//  A light is written on its transfer. A texel write folds MAX_TEXELS off the slot, then writes.
//  Shade: address folds, then a normalization each for the normal, the view and every light,
//  done by the shared normalizer (shift steps, 3 squares, 31-step root, three 16-step divides;
//  a zero vector skips straight to the end).
//  One item in flight; a result waits in the output register while the next
//  item is taken. Asynchronous active-low reset; the stores hold no reset.
// ----------------------------------------------------------------------------
module vertex_diffuse_fresnel_shader #(
    parameter int MAX_TEXELS = vdfs_pkg::DEF_MAX_TEXELS,
    parameter int MAX_LIGHTS = vdfs_pkg::DEF_MAX_LIGHTS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         req_type,
    input  logic [15:0]        slot,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [15:0] norm_x,
    input  logic signed [15:0] norm_y,
    input  logic signed [15:0] norm_z,
    input  logic signed [31:0] tex_s,
    input  logic signed [31:0] tex_t,
    input  logic [23:0]        value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         red,
    output logic [7:0]         green,
    output logic [7:0]         blue
);

    localparam int TEX_AW   = (MAX_TEXELS > 1) ? $clog2(MAX_TEXELS) : 1;
    localparam int LIGHT_AW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
    localparam int LCNT_W   = $clog2(MAX_LIGHTS + 1);
    localparam int ILLUM_W  = 31 + $clog2(MAX_LIGHTS);
    localparam int TOT_W    = ILLUM_W + 10;

    // config
    logic [8:0]  tex_width_reg, tex_height_reg;
    logic [3:0]  light_count_reg;
    logic [15:0] fresnel_gain_reg;
    logic [8:0]  w_eff, h_eff;

    // control
    vdfs_pkg::shd_st_t state_reg, state_next;
    logic              out_valid_reg, out_valid_next;
    logic [4:0]        step_reg, step_next;
    logic [1:0]        k_reg, k_next;
    logic [LIGHT_AW-1:0] lidx_reg, lidx_next;
    logic [LCNT_W-1:0] cnt_reg, cnt_next;
    logic              wr_reg, wr_next;

    // item and datapath
    logic signed [31:0] px_reg, py_reg, pz_reg, s_reg, t_reg;
    logic signed [15:0] nx_reg, ny_reg, nz_reg;
    logic [23:0]        val_reg;
    logic signed [27:0] v_raw_reg, v_raw_next;
    logic [27:0]        md_reg, md_next;
    logic               mneg_reg, mneg_next;
    logic [8:0]         mrem_reg, mrem_next;
    logic [8:0]         u_reg, u_next, v_reg, v_next;
    logic [20:0]        red_addr_reg, red_addr_next;
    logic [23:0]        texel_reg, texel_next;
    vdfs_pkg::nvec_t    n_reg, n_next, view_reg, view_next, l_reg, l_next;
    logic signed [31:0] dot_reg, dot_next;
    logic [ILLUM_W-1:0] illum_reg, illum_next;
    logic [14:0]        a_reg, a_next;
    logic [23:0]        gain255_reg, gain255_next;
    logic [38:0]        rim_reg, rim_next;
    logic [7:0]         ch_reg [3];
    logic [7:0]         ch_next [3];
    logic [7:0]         red_reg, green_reg, blue_reg;
    logic [7:0]         red_next, green_next, blue_next;

    // memories
    logic [23:0]  tex_mem [MAX_TEXELS];
    logic [23:0]  tex_q_reg;
    logic         tex_we;
    logic [111:0] light_mem [MAX_LIGHTS];
    logic [111:0] light_q_reg;
    logic         light_we;
    logic [15:0]  light_int;

    // normalizer
    logic             unit_start, unit_done;
    vdfs_pkg::vec34_t unit_vec;
    vdfs_pkg::nvec_t  unit_res;

    // comb temporaries
    logic               in_xfer;
    logic signed [41:0] prod_u;
    logic signed [32:0] tm;
    logic signed [42:0] prod_v;
    logic signed [27:0] u_comb;
    logic [9:0]         mrem2;
    logic [9:0]         mmod;
    logic signed [15:0] nsel, msel;
    logic signed [31:0] prod_d;
    logic [17:0]        dsh;
    logic [14:0]        cval;
    logic [31:0]        absd;
    logic [7:0]         chan;
    logic [TOT_W-1:0]   tot;
    logic [TOT_W-23:0]  tsh;
    logic [LCNT_W:0]    lnum;

    assign w_eff     = (tex_width_reg == 9'd0) ? 9'd1 : tex_width_reg;
    assign h_eff     = (tex_height_reg == 9'd0) ? 9'd1 : tex_height_reg;
    assign in_ready  = (state_reg == vdfs_pkg::S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign light_we  = in_xfer && (req_type == vdfs_pkg::REQ_LIGHT)
                       && (32'(slot) < 32'(MAX_LIGHTS));
    assign light_int = (value > 24'hFFFF) ? 16'hFFFF : value[15:0];

    vdfs_unitize u_unit (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (unit_start),
        .vec_in  (unit_vec),
        .done    (unit_done),
        .vec_out (unit_res)
    );

    always_ff @(posedge clk)
    begin
        if (tex_we)
        begin
            tex_mem[red_addr_reg[TEX_AW-1:0]] <= val_reg;
        end
        tex_q_reg <= tex_mem[red_addr_reg[TEX_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (light_we)
        begin
            light_mem[slot[LIGHT_AW-1:0]] <= {pos_x, pos_y, pos_z, light_int};
        end
        light_q_reg <= light_mem[lidx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_width_reg    <= 9'd1;
            tex_height_reg   <= 9'd1;
            light_count_reg  <= 4'd0;
            fresnel_gain_reg <= 16'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                vdfs_pkg::CFG_TEX_WIDTH:    tex_width_reg    <= cfg_data[8:0];
                vdfs_pkg::CFG_TEX_HEIGHT:   tex_height_reg   <= cfg_data[8:0];
                vdfs_pkg::CFG_LIGHT_COUNT:  light_count_reg  <= cfg_data[3:0];
                vdfs_pkg::CFG_FRESNEL_GAIN: fresnel_gain_reg <= cfg_data;
                default:                    tex_width_reg    <= tex_width_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            px_reg  <= pos_x;
            py_reg  <= pos_y;
            pz_reg  <= pos_z;
            nx_reg  <= norm_x;
            ny_reg  <= norm_y;
            nz_reg  <= norm_z;
            s_reg   <= tex_s;
            t_reg   <= tex_t;
            val_reg <= value;
        end
    end

    always_comb
    begin
        case (k_reg)
            2'd0:
            begin
                nsel = n_reg.x;
                msel = (state_reg == vdfs_pkg::S_VDOT) ? view_reg.x : l_reg.x;
            end
            2'd1:
            begin
                nsel = n_reg.y;
                msel = (state_reg == vdfs_pkg::S_VDOT) ? view_reg.y : l_reg.y;
            end
            default:
            begin
                nsel = n_reg.z;
                msel = (state_reg == vdfs_pkg::S_VDOT) ? view_reg.z : l_reg.z;
            end
        endcase
        case (k_reg)
            2'd0:    chan = texel_reg[23:16];
            2'd1:    chan = texel_reg[15:8];
            default: chan = texel_reg[7:0];
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        step_next      = step_reg;
        k_next         = k_reg;
        lidx_next      = lidx_reg;
        cnt_next       = cnt_reg;
        wr_next        = wr_reg;
        v_raw_next     = v_raw_reg;
        md_next        = md_reg;
        mneg_next      = mneg_reg;
        mrem_next      = mrem_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        red_addr_next  = red_addr_reg;
        texel_next     = texel_reg;
        n_next         = n_reg;
        view_next      = view_reg;
        l_next         = l_reg;
        dot_next       = dot_reg;
        illum_next     = illum_reg;
        a_next         = a_reg;
        gain255_next   = gain255_reg;
        rim_next       = rim_reg;
        ch_next        = ch_reg;
        red_next       = red_reg;
        green_next     = green_reg;
        blue_next      = blue_reg;
        tex_we         = 1'b0;
        unit_start     = 1'b0;
        unit_vec       = '{x: 34'(nx_reg), y: 34'(ny_reg), z: 34'(nz_reg)};

        prod_u = $signed({1'b0, w_eff}) * s_reg;
        u_comb = 28'((prod_u + 42'sd32768) >>> 16);
        tm     = 33'sd65536 - 33'(t_reg);
        prod_v = $signed({1'b0, h_eff}) * tm;
        mmod   = (state_reg == vdfs_pkg::S_MODU) ? {1'b0, w_eff} : {1'b0, h_eff};
        mrem2  = {mrem_reg, md_reg[27]};
        prod_d = nsel * msel;
        dsh    = dot_reg[31:14];
        cval   = (dsh > 18'(vdfs_pkg::ONE_Q14)) ? vdfs_pkg::ONE_Q14 : dsh[14:0];
        absd   = dot_reg[31] ? 32'(-dot_reg) : 32'(dot_reg);
        tot    = TOT_W'(chan) * TOT_W'(illum_reg) + TOT_W'(rim_reg) + (TOT_W'(1) << 21);
        tsh    = tot[TOT_W-1:22];
        lnum   = (LCNT_W + 1)'(lidx_reg) + (LCNT_W + 1)'(1);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            vdfs_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    case (req_type)
                        vdfs_pkg::REQ_TEXEL:
                        begin
                            red_addr_next = 21'(slot);
                            wr_next       = 1'b1;
                            state_next    = vdfs_pkg::S_RED;
                        end
                        vdfs_pkg::REQ_SHADE:
                        begin
                            wr_next    = 1'b0;
                            state_next = vdfs_pkg::S_UMUL;
                        end
                        default:
                        begin
                            state_next = vdfs_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            vdfs_pkg::S_UMUL:
            begin
                v_raw_next = 28'((prod_v + 43'sd32768) >>> 16);
                mneg_next  = u_comb[27];
                md_next    = u_comb[27] ? 28'(-u_comb) : 28'(u_comb);
                mrem_next  = 9'd0;
                step_next  = 5'd0;
                state_next = vdfs_pkg::S_MODU;
            end
            vdfs_pkg::S_MODU,
            vdfs_pkg::S_MODV:
            begin
                if (mrem2 >= mmod)
                begin
                    mrem2 = mrem2 - mmod;
                end
                mrem_next = mrem2[8:0];
                md_next   = md_reg << 1;
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd27)
                begin
                    step_next = 5'd0;
                    mrem_next = 9'd0;
                    if (state_reg == vdfs_pkg::S_MODU)
                    begin
                        u_next     = (mneg_reg && mrem2[8:0] != 9'd0) ? w_eff - mrem2[8:0]
                                                                       : mrem2[8:0];
                        mneg_next  = v_raw_reg[27];
                        md_next    = v_raw_reg[27] ? 28'(-v_raw_reg) : 28'(v_raw_reg);
                        state_next = vdfs_pkg::S_MODV;
                    end
                    else
                    begin
                        v_next     = (mneg_reg && mrem2[8:0] != 9'd0) ? h_eff - mrem2[8:0]
                                                                       : mrem2[8:0];
                        state_next = vdfs_pkg::S_ADDR;
                    end
                end
            end
            vdfs_pkg::S_ADDR:
            begin
                red_addr_next = 21'(v_reg * w_eff) + 21'(u_reg);
                state_next    = vdfs_pkg::S_RED;
            end
            vdfs_pkg::S_RED:
            begin
                if (red_addr_reg >= 21'(MAX_TEXELS))
                begin
                    red_addr_next = red_addr_reg - 21'(MAX_TEXELS);
                end
                else
                begin
                    state_next = wr_reg ? vdfs_pkg::S_TWR : vdfs_pkg::S_TRD;
                end
            end
            vdfs_pkg::S_TWR:
            begin
                tex_we     = 1'b1;
                state_next = vdfs_pkg::S_IDLE;
            end
            vdfs_pkg::S_TRD:
            begin
                state_next = vdfs_pkg::S_TLAT;
            end
            vdfs_pkg::S_TLAT:
            begin
                texel_next = tex_q_reg;
                state_next = vdfs_pkg::S_NSTART;
            end
            vdfs_pkg::S_NSTART:
            begin
                unit_start = 1'b1;
                state_next = vdfs_pkg::S_NWAIT;
            end
            vdfs_pkg::S_NWAIT:
            begin
                if (unit_done)
                begin
                    n_next     = unit_res;
                    state_next = vdfs_pkg::S_VSTART;
                end
            end
            vdfs_pkg::S_VSTART:
            begin
                unit_vec   = '{x: 34'(px_reg), y: 34'(py_reg), z: 34'(pz_reg)};
                unit_start = 1'b1;
                state_next = vdfs_pkg::S_VWAIT;
            end
            vdfs_pkg::S_VWAIT:
            begin
                if (unit_done)
                begin
                    view_next  = unit_res;
                    illum_next = '0;
                    lidx_next  = '0;
                    cnt_next   = (32'(light_count_reg) > 32'(MAX_LIGHTS))
                                 ? LCNT_W'(MAX_LIGHTS) : LCNT_W'(light_count_reg);
                    k_next     = 2'd0;
                    dot_next   = 32'sd0;
                    if ((light_count_reg == 4'd0))
                    begin
                        state_next = vdfs_pkg::S_VDOT;
                    end
                    else
                    begin
                        state_next = vdfs_pkg::S_LRD;
                    end
                end
            end
            vdfs_pkg::S_LRD:
            begin
                state_next = vdfs_pkg::S_LSTART;
            end
            vdfs_pkg::S_LSTART:
            begin
                unit_vec.x = 34'($signed(light_q_reg[111:80])) - 34'(px_reg);
                unit_vec.y = 34'($signed(light_q_reg[79:48])) - 34'(py_reg);
                unit_vec.z = 34'($signed(light_q_reg[47:16])) - 34'(pz_reg);
                unit_start = 1'b1;
                state_next = vdfs_pkg::S_LWAIT;
            end
            vdfs_pkg::S_LWAIT:
            begin
                if (unit_done)
                begin
                    l_next     = unit_res;
                    k_next     = 2'd0;
                    dot_next   = 32'sd0;
                    state_next = vdfs_pkg::S_LDOT;
                end
            end
            vdfs_pkg::S_LDOT:
            begin
                dot_next = dot_reg + prod_d;
                k_next   = k_reg + 2'd1;
                if (k_reg == 2'd2)
                begin
                    k_next     = 2'd0;
                    state_next = vdfs_pkg::S_LACC;
                end
            end
            vdfs_pkg::S_LACC:
            begin
                if (!dot_reg[31] && dot_reg != 32'sd0)
                begin
                    illum_next = illum_reg + ILLUM_W'(light_q_reg[15:0] * cval);
                end
                lidx_next = lidx_reg + LIGHT_AW'(1);
                dot_next  = 32'sd0;
                if (lnum == (LCNT_W + 1)'(cnt_reg))
                begin
                    state_next = vdfs_pkg::S_VDOT;
                end
                else
                begin
                    state_next = vdfs_pkg::S_LRD;
                end
            end
            vdfs_pkg::S_VDOT:
            begin
                dot_next = dot_reg + prod_d;
                k_next   = k_reg + 2'd1;
                if (k_reg == 2'd2)
                begin
                    k_next     = 2'd0;
                    state_next = vdfs_pkg::S_RIM1;
                end
            end
            vdfs_pkg::S_RIM1:
            begin
                a_next       = (absd[31:14] > 18'(vdfs_pkg::ONE_Q14)) ? vdfs_pkg::ONE_Q14
                                                                     : absd[28:14];
                gain255_next = fresnel_gain_reg * 24'd255;
                state_next   = vdfs_pkg::S_RIM2;
            end
            vdfs_pkg::S_RIM2:
            begin
                rim_next   = 39'(gain255_reg) * 39'(vdfs_pkg::ONE_Q14 - a_reg);
                k_next     = 2'd0;
                state_next = vdfs_pkg::S_CH;
            end
            vdfs_pkg::S_CH:
            begin
                ch_next[k_reg] = (tsh > (TOT_W - 22)'(255)) ? 8'd255 : tsh[7:0];
                k_next         = k_reg + 2'd1;
                if (k_reg == 2'd2)
                begin
                    k_next     = 2'd0;
                    state_next = vdfs_pkg::S_OUT;
                end
            end
            vdfs_pkg::S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    red_next       = ch_reg[0];
                    green_next     = ch_reg[1];
                    blue_next      = ch_reg[2];
                    state_next     = vdfs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = vdfs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vdfs_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= 5'd0;
            k_reg         <= 2'd0;
            lidx_reg      <= '0;
            cnt_reg       <= '0;
            wr_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            k_reg         <= k_next;
            lidx_reg      <= lidx_next;
            cnt_reg       <= cnt_next;
            wr_reg        <= wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_raw_reg    <= v_raw_next;
        md_reg       <= md_next;
        mneg_reg     <= mneg_next;
        mrem_reg     <= mrem_next;
        u_reg        <= u_next;
        v_reg        <= v_next;
        red_addr_reg <= red_addr_next;
        texel_reg    <= texel_next;
        n_reg        <= n_next;
        view_reg     <= view_next;
        l_reg        <= l_next;
        dot_reg      <= dot_next;
        illum_reg    <= illum_next;
        a_reg        <= a_next;
        gain255_reg  <= gain255_next;
        rim_reg      <= rim_next;
        ch_reg       <= ch_next;
        red_reg      <= red_next;
        green_reg    <= green_next;
        blue_reg     <= blue_next;
    end

endmodule

### src/vdfs_unitize.sv
// ----------------------------------------------------------------------------
// Vertex diffuse fresnel shader vector normalizer
// Bit-serial normalize, sum of squares, digit-by-digit root, restoring divide.
// ----------------------------------------------------------------------------
module vdfs_unitize (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  vdfs_pkg::vec34_t vec_in,
    output logic            done,
    output vdfs_pkg::nvec_t vec_out
);

    vdfs_pkg::unit_st_t state_reg, state_next;

    logic [33:0]        mag_reg [3];
    logic [33:0]        mag_next [3];
    logic [2:0]         neg_reg, neg_next;
    logic [61:0]        acc_reg, acc_next;
    logic [61:0]        root_reg, root_next;
    logic [61:0]        bit_reg, bit_next;
    logic [30:0]        len_reg, len_next;
    logic [46:0]        rem_reg, rem_next;
    logic [46:0]        den_reg, den_next;
    logic [15:0]        quo_reg, quo_next;
    logic [1:0]         k_reg, k_next;
    logic [3:0]         j_reg, j_next;
    logic signed [15:0] res_reg [3];
    logic signed [15:0] res_next [3];

    logic signed [33:0] vin [3];
    logic [33:0]        mx;
    logic [59:0]        sq;
    logic [61:0]        trial;
    logic [15:0]        qsat;

    assign vin[0] = vec_in.x;
    assign vin[1] = vec_in.y;
    assign vin[2] = vec_in.z;

    assign vec_out.x = res_reg[0];
    assign vec_out.y = res_reg[1];
    assign vec_out.z = res_reg[2];

    always_comb
    begin
        mx = mag_reg[0];
        if (mag_reg[1] > mx)
        begin
            mx = mag_reg[1];
        end
        if (mag_reg[2] > mx)
        begin
            mx = mag_reg[2];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        root_next  = root_reg;
        bit_next   = bit_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        quo_next   = quo_reg;
        k_next     = k_reg;
        j_next     = j_reg;
        res_next   = res_reg;
        done       = 1'b0;
        sq         = mag_reg[k_reg][29:0] * mag_reg[k_reg][29:0];
        trial      = root_reg + bit_reg;
        qsat       = 16'd0;
        case (state_reg)
            vdfs_pkg::U_IDLE:
            begin
                if (start)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        neg_next[i] = vin[i][33];
                        mag_next[i] = vin[i][33] ? 34'(-vin[i]) : 34'(vin[i]);
                    end
                    state_next = vdfs_pkg::U_SHIFT;
                end
            end
            vdfs_pkg::U_SHIFT:
            begin
                if (mx == 34'd0)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        res_next[i] = 16'sd0;
                    end
                    state_next = vdfs_pkg::U_DONE;
                end
                else if (mx < (34'd1 << 29))
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_next[i] = mag_reg[i] << 1;
                    end
                end
                else if (mx >= (34'd1 << 30))
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_next[i] = mag_reg[i] >> 1;
                    end
                end
                else
                begin
                    acc_next   = 62'd0;
                    k_next     = 2'd0;
                    state_next = vdfs_pkg::U_SQ;
                end
            end
            vdfs_pkg::U_SQ:
            begin
                acc_next = acc_reg + 62'(sq);
                if (k_reg == 2'd2)
                begin
                    root_next  = 62'd0;
                    bit_next   = 62'd1 << 60;
                    state_next = vdfs_pkg::U_SQRT;
                end
                else
                begin
                    k_next = k_reg + 2'd1;
                end
            end
            vdfs_pkg::U_SQRT:
            begin
                if (acc_reg >= trial)
                begin
                    acc_next  = acc_reg - trial;
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg == 62'd1)
                begin
                    len_next   = root_next[30:0];
                    k_next     = 2'd0;
                    j_next     = 4'd0;
                    quo_next   = 16'd0;
                    rem_next   = 47'(mag_reg[0][29:0]) << 14;
                    den_next   = 47'(root_next[30:0]) << 15;
                    state_next = vdfs_pkg::U_DIV;
                end
            end
            vdfs_pkg::U_DIV:
            begin
                if (rem_reg >= den_reg)
                begin
                    rem_next = rem_reg - den_reg;
                    quo_next = {quo_reg[14:0], 1'b1};
                end
                else
                begin
                    quo_next = {quo_reg[14:0], 1'b0};
                end
                den_next = den_reg >> 1;
                j_next   = j_reg + 4'd1;
                if (j_reg == 4'd15)
                begin
                    qsat = (quo_next > 16'(vdfs_pkg::ONE_Q14)) ? 16'(vdfs_pkg::ONE_Q14)
                                                              : quo_next;
                    res_next[k_reg] = neg_reg[k_reg] ? -$signed(qsat) : $signed(qsat);
                    if (k_reg == 2'd2)
                    begin
                        state_next = vdfs_pkg::U_DONE;
                    end
                    else
                    begin
                        k_next   = k_reg + 2'd1;
                        quo_next = 16'd0;
                        rem_next = 47'(mag_reg[k_reg + 2'd1][29:0]) << 14;
                        den_next = 47'(len_reg) << 15;
                    end
                end
            end
            vdfs_pkg::U_DONE:
            begin
                done       = 1'b1;
                state_next = vdfs_pkg::U_IDLE;
            end
            default:
            begin
                state_next = vdfs_pkg::U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vdfs_pkg::U_IDLE;
            k_reg     <= 2'd0;
            j_reg     <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            j_reg     <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        acc_reg  <= acc_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
        len_reg  <= len_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quo_reg  <= quo_next;
        res_reg  <= res_next;
    end

endmodule

### src/vdfs_checker.sv
// ----------------------------------------------------------------------------
// Vertex diffuse fresnel shader port checker
// Port-level properties of the shader, bound to the top level.
// ----------------------------------------------------------------------------
`include "vertex_diffuse_fresnel_shader_assert.svh"

module vdfs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] req_type,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] red,
    input logic [7:0] green,
    input logic [7:0] blue
);

    `VDFS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
    `VDFS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(red) && $stable(green) && $stable(blue), "stalled result changed")
    `VDFS_ASSERT_NEXT(a_write_silent, in_valid && in_ready && req_type != vdfs_pkg::REQ_SHADE, !$rose(out_valid), "write transfer produced a result")
    `VDFS_ASSERT_NEXT(a_shade_busy, in_valid && in_ready && req_type == vdfs_pkg::REQ_SHADE, !in_ready, "shade transfer did not occupy the block")

endmodule

bind vertex_diffuse_fresnel_shader vdfs_checker u_vdfs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red       (red),
    .green     (green),
    .blue      (blue)
);

### sim/vertex_diffuse_fresnel_shader_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex diffuse fresnel shader testbench
// Drives texel writes, light writes and shade requests over valid/ready with
// random gaps and stalls. A scoreboard predicts each shaded pixel in fixed
// point and checks every result transfer field by field, in order.
// ----------------------------------------------------------------------------
module vertex_diffuse_fresnel_shader_tb;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]         kind;
        logic [15:0]        slot;
        logic signed [31:0] px, py, pz;
        logic signed [15:0] nx, ny, nz;
        logic signed [31:0] s, t;
        logic [23:0]        val;
    } req_t;

    typedef struct {
        logic [7:0] r, g, b;
    } pixel_t;

    class shade_scoreboard;
        logic [23:0]   texels [65536];
        longint        lpx [8], lpy [8], lpz [8];
        longint        inten [8];
        int unsigned   width_r, height_r, count_r, gain_r;
        pixel_t        pixels [$];
        int            errors;
        int            n_shade, n_texel, n_light, n_cfg;

        function new();
            width_r = 1;
            height_r = 1;
            count_r = 0;
            gain_r = 0;
            errors = 0;
            foreach (texels[i]) texels[i] = '0;
            foreach (lpx[i])
            begin
                lpx[i] = 0; lpy[i] = 0; lpz[i] = 0; inten[i] = 0;
            end
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] data);
            n_cfg++;
            case (idx)
                vdfs_pkg::CFG_TEX_WIDTH:    width_r = data[8:0];
                vdfs_pkg::CFG_TEX_HEIGHT:   height_r = data[8:0];
                vdfs_pkg::CFG_LIGHT_COUNT:  count_r = data[3:0];
                vdfs_pkg::CFG_FRESNEL_GAIN: gain_r = data;
                default: ;
            endcase
        endfunction

        function longint fdiv(longint a, longint d);
            longint q;
            q = a / d;
            if ((a % d) != 0 && a < 0)
                q--;
            return q;
        endfunction

        function int texel_addr(logic signed [31:0] s, logic signed [31:0] t);
            longint w, h, u, v, ss, tt;
            w = (width_r == 0) ? 1 : width_r;
            h = (height_r == 0) ? 1 : height_r;
            ss = s;
            tt = t;
            u = fdiv(w * ss + 32768, 65536);
            v = fdiv(h * (65536 - tt) + 32768, 65536);
            u = u % w;
            if (u < 0) u += w;
            v = v % h;
            if (v < 0) v += h;
            return int'((v * w + u) % 65536);
        endfunction

        function longint root(longint x);
            longint r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x) b = b >> 2;
            while (b != 0)
            begin
                if (x >= r + b)
                begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function void unit_vec(input longint c [3], output longint n [3]);
            longint m [3];
            longint mx, sum, len, q;
            bit neg [3];
            mx = 0;
            sum = 0;
            for (int i = 0; i < 3; i++)
            begin
                neg[i] = c[i] < 0;
                m[i] = neg[i] ? -c[i] : c[i];
                if (m[i] > mx) mx = m[i];
            end
            if (mx == 0)
            begin
                n[0] = 0; n[1] = 0; n[2] = 0;
                return;
            end
            while (mx < (64'd1 << 29))
            begin
                mx = mx << 1;
                for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
            end
            while (mx >= (64'd1 << 30))
            begin
                mx = mx >> 1;
                for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
            end
            for (int i = 0; i < 3; i++) sum += m[i] * m[i];
            len = root(sum);
            for (int i = 0; i < 3; i++)
            begin
                q = (m[i] << 14) / len;
                if (q > 16384) q = 16384;
                n[i] = neg[i] ? -q : q;
            end
        endfunction

        function void note_request(req_t rq);
            longint pos [3], nrm [3], nu [3], vu [3], dir [3], lu [3];
            longint d, c, a, illum, rim, ch, tot, cnt;
            logic [23:0] tx;
            pixel_t px;
            case (rq.kind)
                vdfs_pkg::REQ_TEXEL:
                begin
                    n_texel++;
                    texels[rq.slot] = rq.val;
                end
                vdfs_pkg::REQ_LIGHT:
                begin
                    n_light++;
                    if (rq.slot < 8)
                    begin
                        lpx[rq.slot] = rq.px;
                        lpy[rq.slot] = rq.py;
                        lpz[rq.slot] = rq.pz;
                        inten[rq.slot] = (rq.val > 24'hFFFF) ? 64'hFFFF : rq.val;
                    end
                end
                vdfs_pkg::REQ_SHADE:
                begin
                    n_shade++;
                    pos[0] = rq.px; pos[1] = rq.py; pos[2] = rq.pz;
                    nrm[0] = rq.nx; nrm[1] = rq.ny; nrm[2] = rq.nz;
                    tx = texels[texel_addr(rq.s, rq.t)];
                    unit_vec(nrm, nu);
                    unit_vec(pos, vu);
                    cnt = (count_r > 8) ? 8 : count_r;
                    illum = 0;
                    for (int i = 0; i < cnt; i++)
                    begin
                        dir[0] = lpx[i] - pos[0];
                        dir[1] = lpy[i] - pos[1];
                        dir[2] = lpz[i] - pos[2];
                        unit_vec(dir, lu);
                        d = nu[0] * lu[0] + nu[1] * lu[1] + nu[2] * lu[2];
                        c = (d > 0) ? (d >> 14) : 0;
                        if (c > 16384) c = 16384;
                        illum += inten[i] * c;
                    end
                    d = nu[0] * vu[0] + nu[1] * vu[1] + nu[2] * vu[2];
                    a = ((d < 0) ? -d : d) >> 14;
                    if (a > 16384) a = 16384;
                    rim = longint'(gain_r) * 255 * (16384 - a);
                    for (int k = 0; k < 3; k++)
                    begin
                        ch = (tx >> (16 - 8 * k)) & 8'hFF;
                        tot = (ch * illum + rim + (64'd1 << 21)) >> 22;
                        if (tot > 255) tot = 255;
                        if (k == 0) px.r = tot[7:0];
                        else if (k == 1) px.g = tot[7:0];
                        else px.b = tot[7:0];
                    end
                    pixels.push_back(px);
                end
                default: ;
            endcase
        endfunction

        function void check_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            pixel_t e;
            if (pixels.size() == 0)
            begin
                $error("unexpected result transfer: red %0d green %0d blue %0d", r, g, b);
                errors++;
                return;
            end
            e = pixels.pop_front();
            if (r !== e.r)
            begin
                $error("red: expected %0d, actual %0d", e.r, r);
                errors++;
            end
            if (g !== e.g)
            begin
                $error("green: expected %0d, actual %0d", e.g, g);
                errors++;
            end
            if (b !== e.b)
            begin
                $error("blue: expected %0d, actual %0d", e.b, b);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         req_type;
    logic [15:0]        slot;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic signed [15:0] norm_x, norm_y, norm_z;
    logic signed [31:0] tex_s, tex_t;
    logic [23:0]        value;
    logic               out_valid;
    logic               out_ready;
    logic [7:0]         red, green, blue;

    shade_scoreboard sb;
    bit              tex_written [65536];
    bit              no_idle;
    bit              hold_req;
    int              stall_cnt;

    vertex_diffuse_fresnel_shader uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .slot(slot),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
        .tex_s(tex_s), .tex_t(tex_t), .value(value),
        .out_valid(out_valid), .out_ready(out_ready),
        .red(red), .green(green), .blue(blue)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (3000) @(posedge clk);
                hold_req = 1'b0;
            end
            else
                out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 22);
        end
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_pixel(red, green, blue);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cnt = 0;
            else
                stall_cnt++;
            if (stall_cnt >= 30000)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic send_req(input req_t rq);
        if (!no_idle && $urandom_range(99) < 22)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        req_type <= rq.kind;
        slot     <= rq.slot;
        pos_x    <= rq.px;
        pos_y    <= rq.py;
        pos_z    <= rq.pz;
        norm_x   <= rq.nx;
        norm_y   <= rq.ny;
        norm_z   <= rq.nz;
        tex_s    <= rq.s;
        tex_t    <= rq.t;
        value    <= rq.val;
        in_valid <= 1'b1;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        sb.note_request(rq);
        if (rq.kind == vdfs_pkg::REQ_TEXEL)
            tex_written[rq.slot] = 1'b1;
    endtask

    function automatic req_t blank_req(logic [1:0] kind);
        req_t rq;
        rq.kind = kind;
        rq.slot = 16'($urandom);
        rq.px = $urandom; rq.py = $urandom; rq.pz = $urandom;
        rq.nx = 16'($urandom); rq.ny = 16'($urandom); rq.nz = 16'($urandom);
        rq.s = $urandom; rq.t = $urandom;
        rq.val = 24'($urandom);
        return rq;
    endfunction

    function automatic logic signed [31:0] rand_pos();
        int sel;
        sel = $urandom_range(3);
        if (sel == 0)
            return $urandom;
        return $signed($urandom_range(0, 1 << 23)) - (1 << 22);
    endfunction

    function automatic logic signed [15:0] rand_norm();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
            return 16'sd0;
        if (sel < 4)
            return 16'($urandom);
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    // shade, first writing the texel it will fetch if that entry is still empty
    task automatic shade(input req_t rq);
        int addr;
        req_t wr;
        addr = sb.texel_addr(rq.s, rq.t);
        if (!tex_written[addr])
        begin
            wr = blank_req(vdfs_pkg::REQ_TEXEL);
            wr.slot = 16'(addr);
            send_req(wr);
        end
        rq.kind = vdfs_pkg::REQ_SHADE;
        send_req(rq);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pixels.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic random_item();
        req_t rq;
        int pick;
        pick = $urandom_range(99);
        rq = blank_req(vdfs_pkg::REQ_SHADE);
        rq.px = rand_pos(); rq.py = rand_pos(); rq.pz = rand_pos();
        if (pick < 45)
        begin
            rq.nx = rand_norm(); rq.ny = rand_norm(); rq.nz = rand_norm();
            if ($urandom_range(7) == 0)
            begin
                rq.s = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
                rq.t = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
            end
            shade(rq);
        end
        else if (pick < 77)
        begin
            rq.kind = vdfs_pkg::REQ_TEXEL;
            send_req(rq);
        end
        else if (pick < 95)
        begin
            rq.kind = vdfs_pkg::REQ_LIGHT;
            if ($urandom_range(5) != 0) rq.slot = 16'($urandom_range(0, 7));
            if ($urandom_range(1)) rq.val = 24'($urandom_range(0, 16'hFFFF));
            send_req(rq);
        end
        else
        begin
            rq.kind = REQ_UNUSED;
            send_req(rq);
        end
    endtask

    initial
    begin
        req_t rq;
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = vdfs_pkg::CFG_TEX_WIDTH; cfg_data = '0;
        in_valid = 1'b0; req_type = vdfs_pkg::REQ_TEXEL; slot = '0;
        pos_x = '0; pos_y = '0; pos_z = '0;
        norm_x = '0; norm_y = '0; norm_z = '0;
        tex_s = '0; tex_t = '0; value = '0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        stall_cnt = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every light, out-of-range light slots, wide intensity, extremes
        for (int i = 0; i < 8; i++)
        begin
            rq = blank_req(vdfs_pkg::REQ_LIGHT);
            rq.slot = 16'(i);
            rq.px = rand_pos(); rq.py = rand_pos(); rq.pz = rand_pos();
            rq.val = (i == 0) ? 24'hFFFFFF : (i == 1) ? 24'h00FFFF :
                     (i == 2) ? 24'h000000 : 24'($urandom_range(0, 16'hFFFF));
            if (i == 3)
            begin
                rq.px = 32'sh7FFFFFFF; rq.py = 32'sh80000000; rq.pz = 32'sh7FFFFFFF;
            end
            send_req(rq);
        end
        rq = blank_req(vdfs_pkg::REQ_LIGHT); rq.slot = 16'd8; send_req(rq);
        rq = blank_req(vdfs_pkg::REQ_LIGHT); rq.slot = 16'hFFFF; send_req(rq);
        rq = blank_req(vdfs_pkg::REQ_TEXEL); rq.slot = 16'd0; rq.val = 24'hFFFFFF;
        send_req(rq);
        rq = blank_req(vdfs_pkg::REQ_TEXEL); rq.slot = 16'hFFFF; rq.val = 24'h000000;
        send_req(rq);
        rq = blank_req(REQ_UNUSED); send_req(rq);
        rq = blank_req(vdfs_pkg::REQ_SHADE); shade(rq);
        settle();
        write_reg(vdfs_pkg::CFG_TEX_WIDTH, 16'd256);
        write_reg(vdfs_pkg::CFG_TEX_HEIGHT, 16'd256);
        write_reg(vdfs_pkg::CFG_LIGHT_COUNT, 16'd8);
        write_reg(vdfs_pkg::CFG_FRESNEL_GAIN, 16'hFFFF);
        rq = blank_req(vdfs_pkg::REQ_SHADE);
        rq.nx = 16'sd0; rq.ny = 16'sd0; rq.nz = 16'sd0;
        shade(rq);
        rq = blank_req(vdfs_pkg::REQ_SHADE);
        rq.px = 0; rq.py = 0; rq.pz = 0;
        shade(rq);
        rq = blank_req(vdfs_pkg::REQ_SHADE);
        rq.px = 32'sh80000000; rq.py = 32'sh80000000; rq.pz = 32'sh80000000;
        rq.nx = 16'sh8000; rq.ny = 16'sh7FFF; rq.nz = 16'sh8000;
        rq.s = 32'sh80000000; rq.t = 32'sh7FFFFFFF;
        shade(rq);
        rq = blank_req(vdfs_pkg::REQ_SHADE);
        rq.s = 32'sh7FFFFFFF; rq.t = 32'sh80000000;
        rq.nx = 16'sh7FFF; rq.ny = 16'sd0; rq.nz = 16'sd0;
        rq.px = 32'sh00010000; rq.py = 0; rq.pz = 0;
        shade(rq);
        settle();
        write_reg(vdfs_pkg::CFG_TEX_WIDTH, 16'hFE00);
        write_reg(vdfs_pkg::CFG_TEX_HEIGHT, 16'd0);
        write_reg(vdfs_pkg::CFG_LIGHT_COUNT, 16'hFFFF);
        write_reg(vdfs_pkg::CFG_FRESNEL_GAIN, 16'd0);
        rq = blank_req(vdfs_pkg::REQ_SHADE); shade(rq);
        rq = blank_req(vdfs_pkg::REQ_SHADE); rq.s = -32'sd1; rq.t = 32'sd1; shade(rq);

        for (int ph = 0; ph < 8; ph++)
        begin
            settle();
            write_reg(vdfs_pkg::CFG_TEX_WIDTH,
                      (ph == 1) ? 16'd256 : (ph == 2) ? 16'd1
                                : 16'($urandom_range(0, 511)));
            write_reg(vdfs_pkg::CFG_TEX_HEIGHT,
                      (ph == 1) ? 16'd256 : (ph == 2) ? 16'd1
                                : 16'($urandom_range(0, 511)));
            write_reg(vdfs_pkg::CFG_LIGHT_COUNT,
                      (ph == 2) ? 16'd0 : (ph == 5) ? 16'd8
                                : 16'($urandom_range(0, 15)));
            write_reg(vdfs_pkg::CFG_FRESNEL_GAIN,
                      (ph == 2) ? 16'hFFFF : (ph == 3) ? 16'd0 : 16'($urandom));
            no_idle = (ph == 3);
            for (int n = 0; n < 130; n++)
            begin
                if (ph == 2 && n == 40)
                    hold_req = 1'b1;
                random_item();
            end
        end

        in_valid <= 1'b0;
        no_idle = 1'b0;
        while (sb.pixels.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        $display("Covered %0d shades, %0d texel writes, %0d light writes, %0d register writes.",
                 sb.n_shade, sb.n_texel, sb.n_light, sb.n_cfg);
        $display("Register settings included zero and maximum sizes and light counts.");
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
